/* hw/rtl/assert_macros.svh */
// ------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the list core.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PDLL_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// A condition that must be followed by another in the next cycle.
`define PDLL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pdll_pkg.sv */
// ------------------------------------------------------------------------
// pdll_pkg
// Types and codes shared by the positional doubly linked list core.
// ------------------------------------------------------------------------
package pdll_pkg;

	// Operation codes.
	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_POS   = 3'd1;
	localparam logic [2:0] OP_INS_END   = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_POS   = 3'd4;
	localparam logic [2:0] OP_DEL_END   = 3'd5;
	localparam logic [2:0] OP_DUMP      = 3'd6;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// Request word.
	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] item_value;
		logic [7:0]         position;
	} req_t;

	// Response word.
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_value;
		logic               backward;
		logic [4:0]         entry_total;
		logic               last;
	} rsp_t;

endpackage

/* hw/rtl/positional_doubly_linked_list_core.sv */
// ------------------------------------------------------------------------
// positional_doubly_linked_list_core
// Ordered list of signed words held in a linked node pool.
// ------------------------------------------------------------------------
// The list lives in three small RAMs (data, forward link, backward link)
// that a sequencer reads and rewrites, one request at a time. Positional
// operations first walk the forward links one node per cycle. A dump
// streams one word per cycle while the receiver does not stall. The
// registered RAM reads and the single write port of each RAM set the pace.
// A response may wait in the output register while the next request is
// already being worked on.
module positional_doubly_linked_list_core #(
	parameter int CAPACITY = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  pdll_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output pdll_pkg::rsp_t  rsp
);

	`include "assert_macros.svh"

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);

	// Sequencer states.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_WALK   = 4'd1;
	localparam logic [3:0] S_I_NXT  = 4'd2;
	localparam logic [3:0] S_I_FREE = 4'd3;
	localparam logic [3:0] S_I_W2   = 4'd4;
	localparam logic [3:0] S_X_RD   = 4'd5;
	localparam logic [3:0] S_X_W2   = 4'd6;
	localparam logic [3:0] S_DUMP   = 4'd7;
	localparam logic [3:0] S_RESP   = 4'd8;

	// Insert kinds.
	localparam logic [1:0] K_FRONT = 2'd0;
	localparam logic [1:0] K_MID   = 2'd1;
	localparam logic [1:0] K_END   = 2'd2;
	localparam logic [1:0] K_DEL   = 2'd3;

	logic [3:0]    state_q;
	logic [1:0]    kind_q;
	logic [LW-1:0] head_q, tail_q, free_q, count_q;
	logic [LW-1:0] rem_q, node_q, prev_q, next_q;
	logic [31:0]   val_q;
	logic [1:0]    st_q;
	logic          dir_q;

	// RAM ports.
	logic          rd_en;
	logic [LW-1:0] rd_link;
	logic          fwe, bwe, dwe;
	logic [LW-1:0] fwa, bwa, dwa;
	logic [LW-1:0] fwdat, bwdat;
	logic [LW-1:0] fwd_rd, bwd_rd;
	logic [31:0]   data_rd;

	logic          accept, out_free, emit, emit_last, dump_word;
	logic [LW-1:0] dump_link;
	logic [8:0]    pos9, cnt9;

	pdll_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_data (
		.clk(clk), .we(dwe), .waddr(dwa[AW-1:0]), .wdata(val_q),
		.re(rd_en), .raddr(rd_link[AW-1:0]), .rdata(data_rd)
	);

	pdll_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_bwd (
		.clk(clk), .we(bwe), .waddr(bwa[AW-1:0]), .wdata(bwdat),
		.re(rd_en), .raddr(rd_link[AW-1:0]), .rdata(bwd_rd)
	);

	pdll_fwd_ram #(.CAPACITY(CAPACITY), .AW(AW), .LW(LW)) u_fwd (
		.clk(clk), .arst_n(arst_n), .we(fwe), .waddr(fwa[AW-1:0]), .wdata(fwdat),
		.re(rd_en), .raddr(rd_link[AW-1:0]), .rdata(fwd_rd)
	);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid || !rsp_stall;
	assign pos9      = {1'b0, req.position};
	assign cnt9      = 9'(count_q);
	assign dump_link = dir_q ? bwd_rd : fwd_rd;

	// RAM addressing and write enables, one read and one write per RAM.
	always_comb begin
		rd_en   = 1'b0;
		rd_link = head_q;
		fwe     = 1'b0;
		fwa     = node_q;
		fwdat   = NIL;
		bwe     = 1'b0;
		bwa     = node_q;
		bwdat   = NIL;
		dwe     = 1'b0;
		dwa     = free_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					rd_en = 1'b1;
					if (req.opcode == pdll_pkg::OP_DEL_END) begin
						rd_link = tail_q;
					end else if (req.opcode == pdll_pkg::OP_INS_FRONT ||
							req.opcode == pdll_pkg::OP_INS_END) begin
						rd_link = free_q;
					end else if (req.opcode == pdll_pkg::OP_INS_POS &&
							(pos9 == 9'd1 || pos9 == cnt9 + 9'd1)) begin
						rd_link = free_q;
					end
				end
			end
			S_WALK: begin
				rd_en   = 1'b1;
				rd_link = fwd_rd;
			end
			S_I_NXT: begin
				rd_en   = 1'b1;
				rd_link = free_q;
			end
			S_I_FREE: begin
				// New node: data and both of its own links.
				dwe = 1'b1;
				dwa = free_q;
				fwe = 1'b1;
				fwa = free_q;
				bwe = 1'b1;
				bwa = free_q;
				unique case (kind_q)
					K_FRONT: begin
						fwdat = head_q;
						bwdat = NIL;
					end
					K_END: begin
						fwdat = NIL;
						bwdat = tail_q;
					end
					default: begin
						fwdat = next_q;
						bwdat = prev_q;
					end
				endcase
			end
			S_I_W2: begin
				// Neighbours point at the new node.
				fwdat = node_q;
				bwdat = node_q;
				unique case (kind_q)
					K_FRONT: begin
						bwe = (head_q != NIL);
						bwa = head_q;
					end
					K_END: begin
						fwe = (tail_q != NIL);
						fwa = tail_q;
					end
					default: begin
						fwe = 1'b1;
						fwa = prev_q;
						bwe = 1'b1;
						bwa = next_q;
					end
				endcase
			end
			S_X_RD: begin
				// Unlink: predecessor skips forward, successor skips back.
				fwe   = (bwd_rd != NIL);
				fwa   = bwd_rd;
				fwdat = fwd_rd;
				bwe   = (fwd_rd != NIL);
				bwa   = fwd_rd;
				bwdat = bwd_rd;
			end
			S_X_W2: begin
				fwe   = 1'b1;
				fwa   = node_q;
				fwdat = free_q;
			end
			S_DUMP: begin
				if (out_free) begin
					if (dump_link != NIL) begin
						rd_en   = 1'b1;
						rd_link = dump_link;
					end else if (!dir_q) begin
						rd_en   = 1'b1;
						rd_link = tail_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign emit      = (state_q == S_DUMP || state_q == S_RESP) && out_free;
	assign emit_last = (state_q == S_RESP) || (dir_q && dump_link == NIL);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NIL;
			tail_q  <= NIL;
			free_q  <= '0;
			count_q <= '0;
			kind_q  <= K_FRONT;
			dir_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q <= req.item_value;
						st_q  <= pdll_pkg::ST_RANGE;
						dir_q <= 1'b0;
						unique case (req.opcode)
							pdll_pkg::OP_INS_FRONT, pdll_pkg::OP_INS_END: begin
								kind_q <= (req.opcode == pdll_pkg::OP_INS_FRONT) ?
									K_FRONT : K_END;
								if (free_q == NIL) begin
									st_q    <= pdll_pkg::ST_FULL;
									state_q <= S_RESP;
								end else begin
									state_q <= S_I_FREE;
								end
							end
							pdll_pkg::OP_INS_POS: begin
								if (pos9 == 9'd0 || pos9 > cnt9 + 9'd1) begin
									state_q <= S_RESP;
								end else if (free_q == NIL) begin
									st_q    <= pdll_pkg::ST_FULL;
									state_q <= S_RESP;
								end else if (pos9 == 9'd1) begin
									kind_q  <= K_FRONT;
									state_q <= S_I_FREE;
								end else if (pos9 == cnt9 + 9'd1) begin
									kind_q  <= K_END;
									state_q <= S_I_FREE;
								end else begin
									// Predecessor sits position-2 links past the head.
									kind_q <= K_MID;
									if (req.position == 8'd2) begin
										prev_q  <= head_q;
										state_q <= S_I_NXT;
									end else begin
										rem_q   <= LW'(req.position - 8'd3);
										state_q <= S_WALK;
									end
								end
							end
							pdll_pkg::OP_DEL_FRONT, pdll_pkg::OP_DEL_END: begin
								kind_q <= K_DEL;
								node_q <= (req.opcode == pdll_pkg::OP_DEL_FRONT) ?
									head_q : tail_q;
								state_q <= (head_q == NIL) ? S_RESP : S_X_RD;
							end
							pdll_pkg::OP_DEL_POS: begin
								kind_q <= K_DEL;
								if (pos9 == 9'd0 || pos9 > cnt9 || head_q == NIL) begin
									state_q <= S_RESP;
								end else if (req.position == 8'd1) begin
									node_q  <= head_q;
									state_q <= S_X_RD;
								end else begin
									rem_q   <= LW'(req.position - 8'd2);
									state_q <= S_WALK;
								end
							end
							pdll_pkg::OP_DUMP: begin
								state_q <= (head_q == NIL) ? S_RESP : S_DUMP;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_WALK: begin
					// One link per cycle until the wanted node is reached.
					if (rem_q == '0) begin
						if (kind_q == K_MID) begin
							prev_q  <= fwd_rd;
							state_q <= S_I_NXT;
						end else begin
							node_q  <= fwd_rd;
							state_q <= S_X_RD;
						end
					end else begin
						rem_q <= rem_q - LW'(1);
					end
				end
				S_I_NXT: begin
					next_q  <= fwd_rd;
					state_q <= S_I_FREE;
				end
				S_I_FREE: begin
					node_q  <= free_q;
					free_q  <= fwd_rd;
					state_q <= S_I_W2;
				end
				S_I_W2: begin
					if (kind_q == K_FRONT) begin
						head_q <= node_q;
						if (head_q == NIL) begin
							tail_q <= node_q;
						end
					end else if (kind_q == K_END) begin
						tail_q <= node_q;
						if (tail_q == NIL) begin
							head_q <= node_q;
						end
					end
					count_q <= count_q + LW'(1);
					st_q    <= pdll_pkg::ST_OK;
					state_q <= S_RESP;
				end
				S_X_RD: begin
					if (bwd_rd == NIL) begin
						head_q <= fwd_rd;
					end
					if (fwd_rd == NIL) begin
						tail_q <= bwd_rd;
					end
					state_q <= S_X_W2;
				end
				S_X_W2: begin
					free_q  <= node_q;
					count_q <= count_q - LW'(1);
					st_q    <= pdll_pkg::ST_OK;
					state_q <= S_RESP;
				end
				S_DUMP: begin
					if (out_free && dump_link == NIL) begin
						if (dir_q) begin
							state_q <= S_IDLE;
						end else begin
							dir_q <= 1'b1;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (emit) begin
			rsp_valid <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid <= 1'b0;
		end
	end

	assign dump_word = (state_q == S_DUMP);

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp.status      <= dump_word ? pdll_pkg::ST_OK : st_q;
			rsp.out_value   <= dump_word ? $signed(data_rd) : 32'sd0;
			rsp.backward    <= dump_word && dir_q;
			rsp.entry_total <= 5'(count_q);
			rsp.last        <= emit_last;
		end
	end

	// Checks.
	`PDLL_ASSERT_ALWAYS(a_count_bound, count_q <= LW'(CAPACITY),
		"entry count exceeds the pool")
	`PDLL_ASSERT_ALWAYS(a_empty_head, state_q != S_IDLE || ((head_q == NIL) == (count_q == '0)),
		"head and entry count disagree")
	`PDLL_ASSERT_ALWAYS(a_full_free, state_q != S_IDLE ||
		((free_q == NIL) == (count_q == LW'(CAPACITY))), "free chain and entry count disagree")
	`PDLL_ASSERT_NEXT(a_busy, accept, state_q != S_IDLE, "accepted word left no work")

endmodule

/* hw/rtl/pdll_ram.sv */
// ------------------------------------------------------------------------
// pdll_ram
// Simple dual-port synchronous RAM with a registered read.
// ------------------------------------------------------------------------
module pdll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hw/rtl/pdll_fwd_ram.sv */
// ------------------------------------------------------------------------
// pdll_fwd_ram
// Forward link RAM; entries never written read as the free chain.
// ------------------------------------------------------------------------
module pdll_fwd_ram #(
	parameter int CAPACITY = 16,
	parameter int AW = 4,
	parameter int LW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [LW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [LW-1:0] rdata
);

	logic [LW-1:0]       mem [CAPACITY];
	logic [CAPACITY-1:0] written_q;
	logic [LW-1:0]       rdata_q;
	logic                rvalid_q;
	logic [AW-1:0]       raddr_q;

	// One flag per entry records that the entry has been written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (we) begin
			written_q[waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q  <= mem[raddr];
			rvalid_q <= written_q[raddr];
			raddr_q  <= raddr;
		end
	end

	// An unwritten entry links to the next node; the last one to null.
	assign rdata = rvalid_q ? rdata_q : LW'(raddr_q) + LW'(1);

endmodule

/* verif/testbench.sv */
// ------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional doubly linked list core. Request
// words come from a directed table and then from random operation streams;
// a behavioural model of the list predicts every response word, and each
// response is compared as a whole word with the oldest prediction.
// ------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 16;
	localparam logic [4:0] NIL = 5'(CAP);
	// Opcode with no operation behind it.
	localparam logic [2:0] OP_BAD = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	pdll_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	pdll_pkg::rsp_t rsp;

	positional_doubly_linked_list_core #(.CAPACITY(CAP)) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// Shadow copy of the list held by the predictor.
	logic [31:0] lst_data [CAP];
	logic [4:0]  lst_fwd [CAP];
	logic [4:0]  lst_bwd [CAP];
	logic [4:0]  lst_head, lst_tail, lst_free, lst_count;

	pdll_pkg::rsp_t pending_rsp [$];
	int   errors = 0;
	bit   hold_rsp = 1'b0;
	bit   rand_go = 1'b0;

	// Directed table: a typed expected word is checked against the last predicted word.
	typedef struct {
		logic [2:0]     op;
		logic [31:0]    val;
		logic [7:0]     pos;
		bit             has_exp;
		pdll_pkg::rsp_t exp;
	} row_t;

	function automatic pdll_pkg::rsp_t mk(logic [1:0] st, logic [31:0] v, logic b,
			logic [4:0] n, logic l);
		pdll_pkg::rsp_t r;
		r.status = st; r.out_value = v; r.backward = b; r.entry_total = n; r.last = l;
		return r;
	endfunction

	function automatic void list_clear();
		for (int i = 0; i < CAP; i++) begin
			lst_data[i] = '0;
			lst_fwd[i] = 5'(i + 1);
			lst_bwd[i] = NIL;
		end
		lst_head = NIL; lst_tail = NIL; lst_free = '0; lst_count = '0;
	endfunction

	function automatic logic [4:0] list_node_at(int p);
		logic [4:0] n;
		n = lst_head;
		for (int i = 1; i < p && n < NIL && i <= CAP; i++)
			n = lst_fwd[n];
		return n;
	endfunction

	function automatic logic [4:0] list_take(logic [31:0] v);
		logic [4:0] n;
		n = lst_free;
		lst_free = lst_fwd[n];
		lst_data[n] = v;
		lst_count++;
		return n;
	endfunction

	function automatic void list_unlink(logic [4:0] n);
		logic [4:0] p, q;
		p = lst_bwd[n];
		q = lst_fwd[n];
		if (p < NIL) lst_fwd[p] = q; else lst_head = q;
		if (q < NIL) lst_bwd[q] = p; else lst_tail = p;
		lst_fwd[n] = lst_free;
		lst_free = n;
		if (lst_count > 0) lst_count--;
	endfunction

	function automatic logic [1:0] list_insert(logic [2:0] op, logic [31:0] v, int p);
		logic [4:0] n, pv, nx;
		logic [2:0] k;
		k = op;
		if (k == pdll_pkg::OP_INS_POS) begin
			if (p < 1 || p > lst_count + 1) return pdll_pkg::ST_RANGE;
			if (p == 1) k = pdll_pkg::OP_INS_FRONT;
			else if (p == lst_count + 1) k = pdll_pkg::OP_INS_END;
		end
		if (lst_free >= NIL) return pdll_pkg::ST_FULL;
		if (k == pdll_pkg::OP_INS_FRONT) begin
			n = list_take(v);
			lst_fwd[n] = lst_head; lst_bwd[n] = NIL;
			if (lst_head < NIL) lst_bwd[lst_head] = n; else lst_tail = n;
			lst_head = n;
			return pdll_pkg::ST_OK;
		end
		if (k == pdll_pkg::OP_INS_END) begin
			n = list_take(v);
			lst_bwd[n] = lst_tail; lst_fwd[n] = NIL;
			if (lst_tail < NIL) lst_fwd[lst_tail] = n; else lst_head = n;
			lst_tail = n;
			return pdll_pkg::ST_OK;
		end
		pv = list_node_at(p - 1);
		if (pv >= NIL) return pdll_pkg::ST_RANGE;
		nx = lst_fwd[pv];
		if (nx >= NIL) return pdll_pkg::ST_RANGE;
		n = list_take(v);
		lst_bwd[n] = pv; lst_fwd[n] = nx; lst_bwd[nx] = n; lst_fwd[pv] = n;
		return pdll_pkg::ST_OK;
	endfunction

	// Predict the response words of one request and queue them.
	task automatic predict_list_op(pdll_pkg::req_t r);
		logic [1:0] st;
		logic [4:0] n;
		case (r.opcode)
			pdll_pkg::OP_INS_FRONT, pdll_pkg::OP_INS_POS, pdll_pkg::OP_INS_END: begin
				st = list_insert(r.opcode, r.item_value, int'(r.position));
				pending_rsp.push_back(mk(st, '0, 1'b0, lst_count, 1'b0));
			end
			pdll_pkg::OP_DEL_FRONT, pdll_pkg::OP_DEL_END: begin
				n = (r.opcode == pdll_pkg::OP_DEL_FRONT) ? lst_head : lst_tail;
				if (n < NIL) begin
					list_unlink(n); st = pdll_pkg::ST_OK;
				end else st = pdll_pkg::ST_RANGE;
				pending_rsp.push_back(mk(st, '0, 1'b0, lst_count, 1'b0));
			end
			pdll_pkg::OP_DEL_POS: begin
				if (r.position < 1 || r.position > lst_count || lst_head >= NIL) begin
					st = pdll_pkg::ST_RANGE;
				end else begin
					n = list_node_at(int'(r.position));
					if (n < NIL) begin
						list_unlink(n); st = pdll_pkg::ST_OK;
					end else st = pdll_pkg::ST_RANGE;
				end
				pending_rsp.push_back(mk(st, '0, 1'b0, lst_count, 1'b0));
			end
			pdll_pkg::OP_DUMP: begin
				if (lst_head >= NIL) begin
					pending_rsp.push_back(mk(pdll_pkg::ST_RANGE, '0, 1'b0, lst_count, 1'b0));
				end else begin
					n = lst_head;
					for (int s = 0; n < NIL && s < CAP; s++) begin
						pending_rsp.push_back(mk(pdll_pkg::ST_OK, lst_data[n], 1'b0,
							lst_count, 1'b0));
						n = lst_fwd[n];
					end
					n = lst_tail;
					for (int s = 0; n < NIL && s < CAP; s++) begin
						pending_rsp.push_back(mk(pdll_pkg::ST_OK, lst_data[n], 1'b1,
							lst_count, 1'b0));
						n = lst_bwd[n];
					end
				end
			end
			default: pending_rsp.push_back(mk(pdll_pkg::ST_RANGE, '0, 1'b0, lst_count, 1'b0));
		endcase
		pending_rsp[pending_rsp.size() - 1].last = 1'b1;
	endtask

	// Offer one request word after an optional random gap and wait for its acceptance.
	// Valid stays high after acceptance unless a gap follows.
	task automatic send_word(pdll_pkg::req_t r, bit gaps);
		int g;
		if (gaps) begin
			g = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
			if (g > 0) begin
				req_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		req <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		predict_list_op(r);
	endtask

	function automatic pdll_pkg::req_t rand_word(int bias);
		pdll_pkg::req_t r;
		int k;
		k = $urandom_range(0, 99);
		r.item_value = $urandom();
		if (k < bias) r.opcode = 3'($urandom_range(0, 2));
		else if (k < 90) r.opcode = 3'($urandom_range(3, 5));
		else if (k < 97) r.opcode = pdll_pkg::OP_DUMP;
		else r.opcode = OP_BAD;
		if ($urandom_range(0, 9) < 8) r.position = 8'($urandom_range(0, lst_count + 2));
		else r.position = 8'($urandom());
		return r;
	endfunction

	// Check each accepted response word against the oldest prediction.
	pdll_pkg::rsp_t want;
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected response %p", $time, rsp);
				errors++;
			end else begin
				want = pending_rsp.pop_front();
				if (rsp !== want) begin
					$display("%0t: expected %p, got %p", $time, want, rsp);
					errors++;
				end
			end
		end
	end

	// Receiver stalls: mostly short, sometimes long, and always on during a hold.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp) rsp_stall <= 1'b1;
			else begin
				g = $urandom_range(0, 19);
				if (g == 0) rsp_stall <= 1'b1;
				else if (g < 5) rsp_stall <= ~rsp_stall;
				else rsp_stall <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted here, while random requests keep coming.
	initial begin
		wait (rand_go);
		repeat (20) @(posedge clk);
		hold_rsp <= 1'b1;
		repeat (400) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	// Directed rows, then random streams.
	initial begin
		row_t tbl [$];
		row_t rw;
		pdll_pkg::req_t r;
		tbl.push_back('{pdll_pkg::OP_DUMP, 32'd0, 8'd0, 1,
			mk(pdll_pkg::ST_RANGE, 0, 0, 0, 1)});
		tbl.push_back('{pdll_pkg::OP_DEL_FRONT, 32'd0, 8'd0, 1,
			mk(pdll_pkg::ST_RANGE, 0, 0, 0, 1)});
		tbl.push_back('{pdll_pkg::OP_DEL_END, 32'd0, 8'd0, 1,
			mk(pdll_pkg::ST_RANGE, 0, 0, 0, 1)});
		tbl.push_back('{pdll_pkg::OP_DEL_POS, 32'd0, 8'd1, 1,
			mk(pdll_pkg::ST_RANGE, 0, 0, 0, 1)});
		tbl.push_back('{pdll_pkg::OP_INS_POS, 32'd5, 8'd0, 1,
			mk(pdll_pkg::ST_RANGE, 0, 0, 0, 1)});
		tbl.push_back('{pdll_pkg::OP_INS_POS, 32'd5, 8'd2, 1,
			mk(pdll_pkg::ST_RANGE, 0, 0, 0, 1)});
		tbl.push_back('{OP_BAD, 32'hFFFFFFFF, 8'hFF, 1,
			mk(pdll_pkg::ST_RANGE, 0, 0, 0, 1)});
		tbl.push_back('{pdll_pkg::OP_INS_FRONT, 32'h80000000, 8'd0, 1,
			mk(pdll_pkg::ST_OK, 0, 0, 1, 1)});
		tbl.push_back('{pdll_pkg::OP_INS_END, 32'h7FFFFFFF, 8'hFF, 1,
			mk(pdll_pkg::ST_OK, 0, 0, 2, 1)});
		tbl.push_back('{pdll_pkg::OP_INS_POS, 32'hFFFFFFFF, 8'd2, 0, '0});
		tbl.push_back('{pdll_pkg::OP_INS_POS, 32'h00000001, 8'd1, 0, '0});
		tbl.push_back('{pdll_pkg::OP_INS_POS, 32'h55555555, 8'd5, 0, '0});
		tbl.push_back('{pdll_pkg::OP_DUMP, 32'd0, 8'd0, 0, '0});
		tbl.push_back('{pdll_pkg::OP_DEL_POS, 32'd0, 8'd0, 0, '0});
		tbl.push_back('{pdll_pkg::OP_DEL_POS, 32'd0, 8'd6, 0, '0});
		tbl.push_back('{pdll_pkg::OP_DEL_POS, 32'd0, 8'd3, 0, '0});
		tbl.push_back('{pdll_pkg::OP_DEL_FRONT, 32'd0, 8'd0, 0, '0});
		tbl.push_back('{pdll_pkg::OP_DEL_END, 32'd0, 8'd0, 0, '0});
		tbl.push_back('{pdll_pkg::OP_DUMP, 32'd0, 8'd0, 0, '0});
		list_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (tbl[i]) begin
			rw = tbl[i];
			r.opcode = rw.op; r.item_value = rw.val; r.position = rw.pos;
			send_word(r, 1'b1);
			if (rw.has_exp && pending_rsp[pending_rsp.size() - 1] !== rw.exp) begin
				$display("%0t: expected %p, got %p", $time, rw.exp,
					pending_rsp[pending_rsp.size() - 1]);
				errors++;
			end
		end
		// Fill the pool to full and overflow it, then drain past empty.
		repeat (18) begin
			r.opcode = 3'($urandom_range(0, 2)); r.item_value = $urandom();
			r.position = 8'($urandom_range(1, lst_count + 1));
			send_word(r, 1'b0);
		end
		r = '0; r.opcode = pdll_pkg::OP_DUMP;
		send_word(r, 1'b0);
		// Sender pause until every predicted word has arrived.
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (18) begin
			r.opcode = 3'($urandom_range(3, 5));
			r.position = 8'($urandom_range(0, lst_count + 1));
			send_word(r, 1'b1);
		end
		// Random streams alternating between growth and shrink phases.
		rand_go = 1'b1;
		for (int i = 0; i < 320; i++)
			send_word(rand_word(((i / 40) % 2) ? 35 : 65), 1'b1);
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) $display("positional_doubly_linked_list_core: match");
		else $display("positional_doubly_linked_list_core: mismatch");
		$finish;
	end

	// Run limit.
	initial begin
		#20ms;
		$display("positional_doubly_linked_list_core: mismatch");
		$finish;
	end
endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/pdll_pkg.sv
hw/rtl/pdll_ram.sv
hw/rtl/pdll_fwd_ram.sv
hw/rtl/positional_doubly_linked_list_core.sv
verif/testbench.sv
